// ===== rtl/core/rme_pkg.sv =====
// Package: opcodes, register indexes, fault codes and sequencer states of the executor.
package rme_pkg;

  localparam int unsigned DW = 64;
  localparam int unsigned CNT_W = $clog2(DW);

  localparam logic [4:0] OP_NOP  = 5'd0;
  localparam logic [4:0] OP_MOV  = 5'd1;
  localparam logic [4:0] OP_STR  = 5'd2;
  localparam logic [4:0] OP_ADD  = 5'd3;
  localparam logic [4:0] OP_SUB  = 5'd4;
  localparam logic [4:0] OP_MUL  = 5'd5;
  localparam logic [4:0] OP_DIV  = 5'd6;
  localparam logic [4:0] OP_AND  = 5'd7;
  localparam logic [4:0] OP_OR   = 5'd8;
  localparam logic [4:0] OP_XOR  = 5'd9;
  localparam logic [4:0] OP_SHR  = 5'd10;
  localparam logic [4:0] OP_SHL  = 5'd11;
  localparam logic [4:0] OP_CMP  = 5'd12;
  localparam logic [4:0] OP_JE   = 5'd13;
  localparam logic [4:0] OP_JL   = 5'd14;
  localparam logic [4:0] OP_JG   = 5'd15;
  localparam logic [4:0] OP_JLE  = 5'd16;
  localparam logic [4:0] OP_JGE  = 5'd17;
  localparam logic [4:0] OP_JMP  = 5'd18;
  localparam logic [4:0] OP_INT  = 5'd19;
  localparam logic [4:0] OP_PUSH = 5'd20;
  localparam logic [4:0] OP_POP  = 5'd21;

  localparam logic [2:0] REG_A   = 3'd1;
  localparam logic [2:0] REG_B   = 3'd2;
  localparam logic [2:0] REG_ERR = 3'd5;

  localparam logic [3:0] KIND_ZERO = 4'd0;
  localparam logic [3:0] KIND_IMM  = 4'd1;
  localparam logic [3:0] KIND_LAST = 4'd8;

  localparam logic [63:0] INT_EXIT  = 64'd0;
  localparam logic [63:0] INT_PRINT = 64'd1;

  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_SEL   = 3'd1;
  localparam logic [2:0] FLT_STORE = 3'd2;
  localparam logic [2:0] FLT_INT   = 3'd3;
  localparam logic [2:0] FLT_PUSH  = 3'd4;
  localparam logic [2:0] FLT_POP   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIX, ST_RSRC, ST_RDST, ST_EXEC, ST_MUL, ST_DIV, ST_DIVF,
    ST_POPR, ST_POPD, ST_RA, ST_RB, ST_RBD, ST_WB, ST_HRD, ST_HOUT
  } state_e;

endpackage

// ===== rtl/core/register_machine_executor.sv =====
// Top level: multi-cycle instruction executor with bit-serial multiply and divide.
//
//  channel  | dir | beat contents
//  s_axis   | in  | one instruction: opcode, destination, operand kind, immediate
//  m_axis   | out | one result: next line, destination value, fault, store/print, halted
//
// An instruction runs fix-up, source read, destination read, execute, write-back;
// print adds reads of A and B, pop a stack read, and multiply and divide run their
// one-bit-per-cycle loops. Once halted, a beat just returns its destination.
// The register file has one read port, so operand reads are sequenced.
// Reset clears registers, compare, line, stack count and halt; the stack needs no clear.
// A new beat is taken in idle while the last result waits; write-back holds until
// the output register is free.
module register_machine_executor #(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // req_type[4:0], dest_reg[8:5], src_kind[12:9], imm_value[76:13], zero pad
  input  logic [79:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // next_line[7:0], result_value[71:8], fault_code[74:72], write_valid[75],
  // write_addr[85:76], write_data[149:86], print_valid[150], print_addr[160:151],
  // print_len[170:161], halted[171], zero pad
  output logic [175:0] m_axis_tdata_o
);
  import rme_pkg::*;

  localparam int unsigned STACK_DEPTH = MEM_WORDS / 2;
  localparam int unsigned SA_W = $clog2(STACK_DEPTH);
  localparam int unsigned SC_W = $clog2(STACK_DEPTH + 1);
  localparam logic [SC_W-1:0] STACK_FULL = SC_W'(STACK_DEPTH);
  localparam logic [63:0] MEM_LIMIT = 64'(MEM_WORDS);

  state_e state_q, state_d;

  logic [63:0] rf [8];
  logic [63:0] stk [STACK_DEPTH];

  logic [4:0]  op_q;
  logic [2:0]  dr_q;
  logic [3:0]  kind_q;
  logic [63:0] imm_q, opnd_q, dst_q, acc_q, aux_q, rd_data_q, stk_rd_q, cmp_q;
  logic        bad_q, halt_q, neg_q, dwr_q, taken_q, wv_q, pv_q;
  logic [2:0]  fcode_q;
  logic [9:0]  wa_q, pa_q, pl_q;
  logic [7:0]  line_q;
  logic [SC_W-1:0] scnt_q;
  logic [CNT_W-1:0] cnt_q;
  logic        ovalid_q;
  logic [175:0] odata_q;

  logic        accept, out_free, rd_en, wr_en;
  logic [2:0]  rd_addr, wr_addr;
  logic [63:0] wr_data, opnd_new, res_val, quo;
  logic [64:0] div_t;
  logic [63:0] div_r;
  logic        div_ge;
  logic        cmp_z, cmp_n;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !ovalid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

  // Advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    rd_addr = dr_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = halt_q ? ST_HRD : ST_FIX;
      ST_FIX:  state_d = ST_RSRC;
      ST_RSRC: begin
        rd_en   = 1'b1;
        rd_addr = 3'(kind_q - 4'd1);
        state_d = ST_RDST;
      end
      ST_RDST: begin
        rd_en   = 1'b1;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_WB;
        case (op_q)
          OP_MUL: state_d = ST_MUL;
          OP_DIV: if (opnd_q != 64'd0) state_d = ST_DIV;
          OP_INT: if (opnd_q == INT_PRINT) state_d = ST_RA;
          OP_POP: if (scnt_q != '0) state_d = ST_POPR;
          default: ;
        endcase
      end
      ST_MUL:  if (cnt_q == CNT_W'(DW - 1)) state_d = ST_WB;
      ST_DIV:  if (cnt_q == CNT_W'(DW - 1)) state_d = ST_DIVF;
      ST_DIVF: state_d = ST_WB;
      ST_POPR: state_d = ST_POPD;
      ST_POPD: state_d = ST_WB;
      ST_RA: begin
        rd_en   = 1'b1;
        rd_addr = REG_A;
        state_d = ST_RB;
      end
      ST_RB: begin
        rd_en   = 1'b1;
        rd_addr = REG_B;
        state_d = ST_RBD;
      end
      ST_RBD:  state_d = ST_WB;
      ST_WB:   if (out_free) state_d = ST_IDLE;
      ST_HRD: begin
        rd_en   = 1'b1;
        state_d = ST_HOUT;
      end
      ST_HOUT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Register file write port: error fix-up or write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = REG_ERR;
    wr_data = 64'(FLT_SEL);
    if (state_q == ST_FIX) begin
      wr_en = bad_q;
    end else if (state_q == ST_WB && out_free) begin
      if (fcode_q != FLT_NONE) begin
        wr_en   = 1'b1;
        wr_data = 64'(fcode_q);
      end else if (dwr_q) begin
        wr_en   = 1'b1;
        wr_addr = dr_q;
        wr_data = acc_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) rf[i] <= '0;
    end else if (wr_en) begin
      rf[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= rf[rd_addr];
  end

  // Operand from the source read
  always_comb begin
    if (kind_q == KIND_ZERO)      opnd_new = '0;
    else if (kind_q == KIND_IMM)  opnd_new = imm_q;
    else if (kind_q <= KIND_LAST) opnd_new = rd_data_q + imm_q;
    else                          opnd_new = 64'(FLT_SEL);
  end

  // One restoring divide step
  assign div_t  = {aux_q, acc_q[63]};
  assign div_ge = div_t >= {1'b0, opnd_q};
  assign div_r  = div_ge ? 64'(div_t - {1'b0, opnd_q}) : div_t[63:0];
  assign quo    = neg_q ? (64'd0 - acc_q) : acc_q;

  assign cmp_z = (cmp_q == 64'd0);
  assign cmp_n = cmp_q[63];

  // Compare register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_q <= '0;
    end else if (state_q == ST_EXEC && op_q == OP_CMP) begin
      cmp_q <= rd_data_q - opnd_q;
    end
  end

  // Stack memory
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC && op_q == OP_PUSH && scnt_q < STACK_FULL) begin
      stk[scnt_q[SA_W-1:0]] <= opnd_q;
    end
    if (state_q == ST_POPR) stk_rd_q <= stk[SA_W'(scnt_q - SC_W'(1))];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_q   <= s_axis_tdata_i[4:0];
          dr_q   <= s_axis_tdata_i[8] ? REG_ERR : s_axis_tdata_i[7:5];
          kind_q <= s_axis_tdata_i[12:9];
          imm_q  <= s_axis_tdata_i[76:13];
          bad_q  <= s_axis_tdata_i[8] || (s_axis_tdata_i[12:9] > KIND_LAST);
        end
      end
      ST_RDST: opnd_q <= opnd_new;
      ST_EXEC: begin
        dst_q   <= rd_data_q;
        acc_q   <= rd_data_q;
        dwr_q   <= 1'b0;
        taken_q <= 1'b0;
        fcode_q <= FLT_NONE;
        wv_q    <= 1'b0;
        wa_q    <= '0;
        pv_q    <= 1'b0;
        pa_q    <= '0;
        pl_q    <= '0;
        cnt_q   <= '0;
        case (op_q)
          OP_NOP: ;
          OP_MOV: begin acc_q <= opnd_q; dwr_q <= 1'b1; end
          OP_STR: begin
            if (opnd_q[63] || opnd_q >= MEM_LIMIT) begin
              fcode_q <= FLT_STORE;
            end else begin
              wv_q <= 1'b1;
              wa_q <= opnd_q[9:0];
            end
          end
          OP_ADD: begin acc_q <= rd_data_q + opnd_q; dwr_q <= 1'b1; end
          OP_SUB: begin acc_q <= rd_data_q - opnd_q; dwr_q <= 1'b1; end
          OP_MUL: begin acc_q <= '0; aux_q <= rd_data_q; dwr_q <= 1'b1; end
          OP_DIV: begin
            acc_q  <= rd_data_q[63] ? (64'd0 - rd_data_q) : rd_data_q;
            aux_q  <= '0;
            opnd_q <= opnd_q[63] ? (64'd0 - opnd_q) : opnd_q;
            neg_q  <= rd_data_q[63] ^ opnd_q[63];
            dwr_q  <= (opnd_q != 64'd0);
          end
          OP_AND: begin acc_q <= rd_data_q & opnd_q; dwr_q <= 1'b1; end
          OP_OR:  begin acc_q <= rd_data_q | opnd_q; dwr_q <= 1'b1; end
          OP_XOR: begin acc_q <= rd_data_q ^ opnd_q; dwr_q <= 1'b1; end
          OP_SHR: begin acc_q <= 64'($signed(rd_data_q) >>> opnd_q[5:0]); dwr_q <= 1'b1; end
          OP_SHL: begin acc_q <= rd_data_q << opnd_q[5:0]; dwr_q <= 1'b1; end
          OP_CMP: ;
          OP_JE:  taken_q <= cmp_z;
          OP_JL:  taken_q <= cmp_n;
          OP_JG:  taken_q <= !cmp_n && !cmp_z;
          OP_JLE: taken_q <= cmp_n || cmp_z;
          OP_JGE: taken_q <= !cmp_n;
          OP_JMP: taken_q <= 1'b1;
          OP_INT: begin
            if (opnd_q == INT_PRINT) pv_q <= 1'b1;
            else if (opnd_q != INT_EXIT) fcode_q <= FLT_INT;
          end
          OP_PUSH: if (scnt_q >= STACK_FULL) fcode_q <= FLT_PUSH;
          OP_POP:  if (scnt_q == '0) fcode_q <= FLT_POP;
          default: fcode_q <= FLT_SEL;
        endcase
      end
      ST_MUL: begin
        if (opnd_q[0]) acc_q <= acc_q + aux_q;
        aux_q  <= aux_q << 1;
        opnd_q <= opnd_q >> 1;
        cnt_q  <= cnt_q + CNT_W'(1);
      end
      ST_DIV: begin
        aux_q <= div_r;
        acc_q <= {acc_q[62:0], div_ge};
        cnt_q <= cnt_q + CNT_W'(1);
      end
      ST_DIVF: acc_q <= quo;
      ST_POPD: begin acc_q <= stk_rd_q; dwr_q <= 1'b1; end
      ST_RB:   pa_q <= rd_data_q[9:0];
      ST_RBD:  pl_q <= rd_data_q[63] ? 10'd0 :
                       (rd_data_q > 64'd1023 ? 10'd1023 : rd_data_q[9:0]);
      default: ;
    endcase
  end

  // Destination value after the instruction
  always_comb begin
    if (fcode_q != FLT_NONE && dr_q == REG_ERR) res_val = 64'(fcode_q);
    else if (dwr_q)                             res_val = acc_q;
    else                                        res_val = dst_q;
  end

  // Control state: line, stack count, halt, output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q   <= '0;
      scnt_q   <= '0;
      halt_q   <= 1'b0;
      ovalid_q <= 1'b0;
      odata_q  <= '0;
    end else begin
      if (m_axis_tready_i) ovalid_q <= 1'b0;
      if (state_q == ST_EXEC && op_q == OP_PUSH && scnt_q < STACK_FULL) begin
        scnt_q <= scnt_q + SC_W'(1);
      end
      if (state_q == ST_POPR) scnt_q <= scnt_q - SC_W'(1);
      if (state_q == ST_WB && out_free) begin
        line_q   <= taken_q ? 8'(opnd_q - 64'd1) : line_q + 8'd1;
        if (op_q == OP_INT && opnd_q == INT_EXIT) halt_q <= 1'b1;
        ovalid_q <= 1'b1;
        odata_q  <= {4'd0, (op_q == OP_INT && opnd_q == INT_EXIT), pl_q, pa_q, pv_q,
                     (wv_q ? dst_q : 64'd0), wa_q, wv_q,
                     (fcode_q != FLT_NONE ? fcode_q : (bad_q ? FLT_SEL : FLT_NONE)),
                     res_val,
                     (taken_q ? 8'(opnd_q - 64'd1) : line_q + 8'd1)};
      end
      if (state_q == ST_HOUT && out_free) begin
        ovalid_q <= 1'b1;
        odata_q  <= {4'd0, 1'b1, 96'd0, FLT_NONE, rd_data_q, line_q};
      end
    end
  end

  // Checks
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scnt_q <= STACK_FULL) else $error("stack count beyond depth");
  a_store_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && odata_q[75] |-> odata_q[74:72] != FLT_STORE)
    else $error("store request with store range fault");
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOUT |-> $past(halt_q)) else $error("halted path without halt");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(halt_q) |-> halt_q) else $error("halt flag cleared");

endmodule

// ===== verif/tb_register_machine_executor.sv =====
// Testbench for register_machine_executor: directed table, stack overflow, then random programs, checked per beat.
module tb_register_machine_executor;
  timeunit 1ns;
  timeprecision 1ps;
  import rme_pkg::*;

  localparam int unsigned STACK_DEPTH = 512;
  localparam int unsigned RAND_ITEMS = 300;
  localparam int unsigned POP_ITEMS = 16;

  typedef struct packed {
    logic [63:0] imm;
    logic [3:0]  kind;
    logic [3:0]  dst;
    logic [4:0]  op;
  } instr_t;

  typedef struct packed {
    logic        halted;
    logic [9:0]  print_len;
    logic [9:0]  print_addr;
    logic        print_valid;
    logic [63:0] write_data;
    logic [9:0]  write_addr;
    logic        write_valid;
    logic [2:0]  fault;
    logic [63:0] value;
    logic [7:0]  next_line;
  } outcome_t;

  // one directed row: instruction, plus an optional typed-in expectation
  typedef struct {
    instr_t   ins;
    logic     fixed;
    outcome_t want;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [79:0]  s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [175:0] m_axis_tdata_o;

  register_machine_executor u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [63:0] regs [8];
  logic [63:0] cmp_val;
  logic [7:0]  line_q;
  logic [63:0] stack_mem [STACK_DEPTH];
  int unsigned stack_cnt;
  logic        halt_q;

  outcome_t expected_q[$];
  int unsigned mismatches = 0;
  logic        drain_phase = 1'b0;
  logic        hold_long = 1'b0;

  function automatic logic [63:0] div_signed(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic outcome_t execute(instr_t ins);
    outcome_t r;
    logic [2:0]  d;
    logic [63:0] opnd;
    logic [7:0]  nxt;
    logic        taken;
    r = '0;
    d = ins.dst[3] ? REG_ERR : ins.dst[2:0];
    opnd = '0;
    taken = 1'b0;
    nxt = line_q + 8'd1;
    if (halt_q) begin
      r.next_line = line_q;
      r.value = regs[d];
      r.halted = 1'b1;
      return r;
    end
    if (ins.dst[3]) begin
      r.fault = FLT_SEL;
      regs[REG_ERR] = 64'(FLT_SEL);
    end
    if (ins.kind == KIND_ZERO) opnd = '0;
    else if (ins.kind == KIND_IMM) opnd = ins.imm;
    else if (ins.kind <= KIND_LAST) opnd = regs[3'(ins.kind - 4'd1)] + ins.imm;
    else begin
      r.fault = FLT_SEL;
      regs[REG_ERR] = 64'(FLT_SEL);
      opnd = regs[REG_ERR];
    end
    case (ins.op)
      OP_NOP: ;
      OP_MOV: regs[d] = opnd;
      OP_STR: begin
        if (opnd[63] || opnd >= 64'd1024) begin
          r.fault = FLT_STORE;
          regs[REG_ERR] = 64'(FLT_STORE);
        end else begin
          r.write_valid = 1'b1;
          r.write_addr = opnd[9:0];
          r.write_data = regs[d];
        end
      end
      OP_ADD: regs[d] = regs[d] + opnd;
      OP_SUB: regs[d] = regs[d] - opnd;
      OP_MUL: regs[d] = regs[d] * opnd;
      OP_DIV: if (opnd != 0) regs[d] = div_signed(regs[d], opnd);
      OP_AND: regs[d] = regs[d] & opnd;
      OP_OR:  regs[d] = regs[d] | opnd;
      OP_XOR: regs[d] = regs[d] ^ opnd;
      OP_SHR: regs[d] = $signed(regs[d]) >>> opnd[5:0];
      OP_SHL: regs[d] = regs[d] << opnd[5:0];
      OP_CMP: cmp_val = regs[d] - opnd;
      OP_JE:  taken = cmp_val == 0;
      OP_JL:  taken = cmp_val[63];
      OP_JG:  taken = !cmp_val[63] && cmp_val != 0;
      OP_JLE: taken = cmp_val[63] || cmp_val == 0;
      OP_JGE: taken = !cmp_val[63];
      OP_JMP: taken = 1'b1;
      OP_INT: begin
        if (opnd == INT_PRINT) begin
          r.print_valid = 1'b1;
          r.print_addr = regs[REG_A][9:0];
          r.print_len = regs[REG_B][63] ? 10'd0 :
                        (regs[REG_B] > 64'd1023 ? 10'd1023 : regs[REG_B][9:0]);
        end else if (opnd == INT_EXIT) begin
          halt_q = 1'b1;
        end else begin
          r.fault = FLT_INT;
          regs[REG_ERR] = 64'(FLT_INT);
        end
      end
      OP_PUSH: begin
        if (stack_cnt >= STACK_DEPTH) begin
          r.fault = FLT_PUSH;
          regs[REG_ERR] = 64'(FLT_PUSH);
        end else begin
          stack_mem[9'(stack_cnt)] = opnd;
          stack_cnt++;
        end
      end
      OP_POP: begin
        if (stack_cnt == 0) begin
          r.fault = FLT_POP;
          regs[REG_ERR] = 64'(FLT_POP);
        end else begin
          stack_cnt--;
          regs[d] = stack_mem[9'(stack_cnt)];
        end
      end
      default: begin
        r.fault = FLT_SEL;
        regs[REG_ERR] = 64'(FLT_SEL);
      end
    endcase
    if (taken) nxt = 8'(opnd - 64'd1);
    line_q = nxt;
    r.next_line = line_q;
    r.value = regs[d];
    r.halted = halt_q;
    return r;
  endfunction

  function automatic instr_t mk(logic [4:0] op, logic [3:0] dst, logic [3:0] kind,
                                logic [63:0] imm);
    instr_t i;
    i.op = op; i.dst = dst; i.kind = kind; i.imm = imm;
    return i;
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 40));
      1: return -64'($urandom_range(1, 40));
      2: return {1'b1, 63'd0};
      3: return {1'b0, {63{1'b1}}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // random instruction, biased to legal selectors and small operands
  function automatic instr_t rand_instr(int unsigned phase);
    instr_t i;
    int unsigned p;
    p = $urandom_range(0, 99);
    i.op = (p < 90) ? 5'($urandom_range(0, 21)) : 5'($urandom_range(22, 31));
    if (i.op == OP_INT && phase < 2 && $urandom_range(0, 3) != 0)
      i.op = OP_ADD;
    i.dst = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 7));
    i.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    i.imm = rand64();
    if (i.op == OP_INT) begin
      i.kind = KIND_IMM;
      i.imm = (phase < 2) ? 64'($urandom_range(1, 3)) : 64'($urandom_range(0, 3));
      if (i.imm == INT_EXIT && $urandom_range(0, 19) != 0) i.imm = INT_PRINT;
    end
    return i;
  endfunction

  // send one beat, honouring random gaps on the sender side
  task automatic send(instr_t ins);
    if (!drain_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tdata_i <= {3'd0, ins};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_q.push_back(execute(ins));
    @(negedge clk_i);
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    outcome_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[171:0];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result differs: line %0d/%0d val %h/%h flt %0d/%0d halt %b/%b",
                     want.next_line, got.next_line, want.value, got.value,
                     want.fault, got.fault, want.halted, got.halted);
            $display("  wr %b %h %h/%b %h %h pr %b %h %h/%b %h %h",
                     want.write_valid, want.write_addr, want.write_data,
                     got.write_valid, got.write_addr, got.write_data,
                     want.print_valid, want.print_addr, want.print_len,
                     got.print_valid, got.print_addr, got.print_len);
          end
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off, none while draining
  initial begin
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        m_axis_tready_i <= 1'b0;
        repeat (200) @(negedge clk_i);
        hold_long = 1'b0;
        m_axis_tready_i <= 1'b1;
      end else if (!drain_phase && $urandom_range(0, 4) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    row_t rows[$];
    outcome_t w;
    int unsigned n;
    for (int k = 0; k < 8; k++) regs[k] = '0;
    cmp_val = '0; line_q = '0; stack_cnt = 0; halt_q = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows: expectations typed where obvious
    w = '0; w.next_line = 8'd1;
    rows.push_back('{mk(OP_NOP, 4'd0, KIND_ZERO, 64'd0), 1'b1, w});
    w = '0; w.next_line = 8'd2; w.value = {1'b0, {63{1'b1}}};
    rows.push_back('{mk(OP_MOV, 4'd1, KIND_IMM, {1'b0, {63{1'b1}}}), 1'b1, w});
    w = '0; w.next_line = 8'd3; w.value = 64'd0; w.fault = FLT_SEL;
    rows.push_back('{mk(OP_MOV, 4'd15, KIND_ZERO, 64'd0), 1'b1, w});
    w = '0; w.next_line = 8'd4; w.value = 64'd1; w.fault = FLT_SEL;
    rows.push_back('{mk(5'd31, 4'd5, KIND_ZERO, 64'd0), 1'b1, w});
    w = '0; w.next_line = 8'd5; w.value = 64'd2; w.fault = FLT_STORE;
    rows.push_back('{mk(OP_STR, 4'd5, KIND_IMM, {1'b1, 63'd0}), 1'b1, w});
    w = '0; w.next_line = 8'd6; w.value = 64'd5; w.fault = FLT_POP;
    rows.push_back('{mk(OP_POP, 4'd5, KIND_ZERO, 64'd0), 1'b1, w});
    w = '0; w.next_line = 8'd7; w.value = 64'd3; w.fault = FLT_INT;
    rows.push_back('{mk(OP_INT, 4'd5, KIND_IMM, 64'd7), 1'b1, w});
    rows.push_back('{mk(OP_MOV, 4'd2, KIND_IMM, {1'b1, 63'd0}), 1'b0, '0});
    rows.push_back('{mk(OP_DIV, 4'd2, KIND_IMM, '1), 1'b0, '0});
    rows.push_back('{mk(OP_DIV, 4'd2, KIND_ZERO, 64'd0), 1'b0, '0});
    rows.push_back('{mk(OP_MUL, 4'd1, 4'd3, 64'd3), 1'b0, '0});
    rows.push_back('{mk(OP_SHR, 4'd2, KIND_IMM, 64'd127), 1'b0, '0});
    rows.push_back('{mk(OP_SHL, 4'd1, KIND_IMM, 64'd65), 1'b0, '0});
    rows.push_back('{mk(OP_STR, 4'd1, KIND_IMM, 64'd1023), 1'b0, '0});
    rows.push_back('{mk(OP_STR, 4'd1, KIND_IMM, 64'd1024), 1'b0, '0});
    rows.push_back('{mk(OP_INT, 4'd0, KIND_IMM, INT_PRINT), 1'b0, '0});
    rows.push_back('{mk(OP_PUSH, 4'd0, 4'd9, 64'd0), 1'b0, '0});
    rows.push_back('{mk(OP_POP, 4'd4, KIND_ZERO, 64'd0), 1'b0, '0});
    rows.push_back('{mk(OP_AND, 4'd3, 4'd8, '1), 1'b0, '0});
    rows.push_back('{mk(OP_OR, 4'd3, 4'd7, 64'h5555), 1'b0, '0});
    rows.push_back('{mk(OP_XOR, 4'd6, 4'd2, '1), 1'b0, '0});
    rows.push_back('{mk(OP_CMP, 4'd1, KIND_IMM, 64'd0), 1'b0, '0});
    for (int j = 0; j < 5; j++)
      rows.push_back('{mk(5'(OP_JE + j), 4'd0, KIND_IMM, 64'd300), 1'b0, '0});
    rows.push_back('{mk(OP_JMP, 4'd0, KIND_ZERO, 64'd0), 1'b0, '0});

    foreach (rows[r]) begin
      send(rows[r].ins);
      if (rows[r].fixed && expected_q[$] !== rows[r].want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: typed %h, predicted %h", r, rows[r].want, expected_q[$]);
      end
    end

    // long receiver hold-off while instructions keep coming
    hold_long = 1'b1;
    for (int j = 0; j < 20; j++) send(rand_instr(0));

    // stack fill to overflow, then unwind part of it
    for (int j = 0; j < STACK_DEPTH + 2; j++)
      send(mk(OP_PUSH, 4'($urandom_range(0, 7)), 4'($urandom_range(0, 8)), rand64()));
    for (int j = 0; j < POP_ITEMS; j++)
      send(mk(OP_POP, 4'($urandom_range(0, 7)), KIND_ZERO, 64'd0));

    // random programs
    n = 0;
    while (n < RAND_ITEMS) begin
      if (n > RAND_ITEMS - 100) drain_phase = 1'b1;
      send(rand_instr(n > RAND_ITEMS - 20 ? 2 : 0));
      n++;
    end
    // finish with an exit then a few halted beats
    send(mk(OP_INT, 4'd0, KIND_ZERO, 64'd0));
    for (int j = 0; j < 4; j++) send(rand_instr(0));
    s_axis_tvalid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("register_machine_executor: match");
    else
      $display("register_machine_executor: mismatch");
    $finish;
  end

  // hard stop
  initial begin
    #5ms;
    $display("register_machine_executor: mismatch");
    $finish;
  end

endmodule
